FILE: rtl/core/afs_pkg.sv
// shared types and constants for the animation frame sequencer
package afs_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_FRAME_COUNT    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_DELAY_PER_UNIT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_REPEAT_DELAY   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_START_FRAME    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_END_FRAME      = 3'd4;
    localparam logic [CFG_AW-1:0] REG_REPEAT_TIMES   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_STOP_FRAME     = 3'd6;

    // request opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_SEEK    = 2'd3;

    // play status codes
    localparam logic [1:0] ST_PLAYING      = 2'd0;
    localparam logic [1:0] ST_JUMP_PENDING = 2'd1;
    localparam logic [1:0] ST_STOP_PENDING = 2'd2;
    localparam logic [1:0] ST_STOPPED      = 2'd3;

    localparam logic [6:0]  NONE_SHOWN  = 7'h7F;
    localparam logic [6:0]  FRAME_AUTO  = 7'h7F;
    localparam logic [47:0] ELAPSED_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] tick_time;
        logic [5:0]  frame_index;
        logic [15:0] delay_units;
    } in_item_t;

    typedef struct packed {
        logic [5:0] current_frame;
        logic       new_frame_shown;
        logic       completed;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  frame_count;
        logic [31:0] delay_per_unit;
        logic [15:0] repeat_delay;
        logic [5:0]  start_frame;
        logic [6:0]  end_frame;
        logic [15:0] repeat_times;
        logic [6:0]  stop_frame;
    } cfg_t;

    typedef struct packed {
        logic [6:0]  cur_frame;
        logic [47:0] elapsed;
        logic        wrapped_once;
        logic [1:0]  play_status;
        logic [15:0] repeats_left;
        logic [6:0]  shown_frame;
        logic [6:0]  resolved_end;
        logic [6:0]  resolved_stop;
    } state_t;

endpackage

FILE: rtl/core/animation_frame_sequencer.sv
// animation frame sequencer top level: request register, step logic, result register
// a request waits in the request register until the result register is free
// one request per cycle when m_ready allows; delay table read is prefetched for next frame
// a delay load that hits the prefetched frame is forwarded around the ram
// reset (aresetn low, synchronous) clears control and play state, frame delays stay undefined
module animation_frame_sequencer #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  afs_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output afs_pkg::out_item_t         m_data,
    input  logic                       cfg_we,
    input  logic [afs_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [afs_pkg::CFG_DW-1:0] cfg_wdata
);
    import afs_pkg::*;

    localparam int AW = $clog2(MAX_FRAMES);
    localparam logic [10:0] MAXF = 11'(MAX_FRAMES);

    cfg_t      cfg;
    in_item_t  in_reg;
    logic      in_valid_reg;
    logic      in_valid_next;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    state_t    st_reg;
    state_t    st_step;
    state_t    st_next;
    out_item_t res;
    logic      fire;
    logic      wr_en;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;
    logic [15:0]   delay;
    logic          fwd_hit_reg;
    logic          fwd_hit_next;
    logic [15:0]   fwd_data_reg;

    afs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !m_ready);

    assign delay = fwd_hit_reg ? fwd_data_reg : rdata;

    afs_step #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_step (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (in_reg),
        .delay   (delay),
        .st_next (st_step),
        .res     (res)
    );

    assign st_next = fire ? st_step : st_reg;

    // delay table write and prefetch of the frame current after this cycle
    assign wr_en = fire && in_reg.opcode == OP_LOAD &&
                   11'(in_reg.frame_index) < MAXF;
    assign waddr = AW'(in_reg.frame_index);
    assign raddr = AW'(st_next.cur_frame);
    assign fwd_hit_next = wr_en && waddr == raddr;

    afs_ram #(
        .WIDTH (16),
        .DEPTH (MAX_FRAMES)
    ) u_delays (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (in_reg.delay_units),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            fwd_hit_reg         <= 1'b0;
            st_reg.cur_frame     <= '0;
            st_reg.elapsed       <= '0;
            st_reg.wrapped_once  <= 1'b0;
            st_reg.play_status   <= ST_PLAYING;
            st_reg.repeats_left  <= '0;
            st_reg.shown_frame   <= NONE_SHOWN;
            st_reg.resolved_end  <= '0;
            st_reg.resolved_stop <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            st_reg        <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire) begin
            out_reg <= res;
        end
        fwd_data_reg <= in_reg.delay_units;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/core/afs_ram.sv
// generic single write port ram with registered read
module afs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/afs_cfg_regs.sv
// configuration register file with write decode
module afs_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [afs_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [afs_pkg::CFG_DW-1:0] cfg_wdata,
    output afs_pkg::cfg_t              cfg
);
    import afs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_FRAME_COUNT:    cfg_next.frame_count    = cfg_wdata[6:0];
                REG_DELAY_PER_UNIT: cfg_next.delay_per_unit = cfg_wdata[31:0];
                REG_REPEAT_DELAY:   cfg_next.repeat_delay   = cfg_wdata[15:0];
                REG_START_FRAME:    cfg_next.start_frame    = cfg_wdata[5:0];
                REG_END_FRAME:      cfg_next.end_frame      = cfg_wdata[6:0];
                REG_REPEAT_TIMES:   cfg_next.repeat_times   = cfg_wdata[15:0];
                REG_STOP_FRAME:     cfg_next.stop_frame     = cfg_wdata[6:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_count    <= '0;
            cfg_reg.delay_per_unit <= '0;
            cfg_reg.repeat_delay   <= '0;
            cfg_reg.start_frame    <= '0;
            cfg_reg.end_frame      <= FRAME_AUTO;
            cfg_reg.repeat_times   <= '0;
            cfg_reg.stop_frame     <= FRAME_AUTO;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/afs_step.sv
// next-state and result logic for one request
module afs_step #(
    parameter int MAX_FRAMES = 64
) (
    input  afs_pkg::cfg_t      cfg,
    input  afs_pkg::state_t    st,
    input  afs_pkg::in_item_t  item,
    input  logic [15:0]        delay,
    output afs_pkg::state_t    st_next,
    output afs_pkg::out_item_t res
);
    import afs_pkg::*;

    localparam logic [10:0] MAXF = 11'(MAX_FRAMES);

    logic [6:0]  n;
    logic [6:0]  last;
    logic [6:0]  res_end;
    logic [16:0] units;
    logic [48:0] interval;
    logic [48:0] esum;
    logic [47:0] e1;
    logic [47:0] e2;
    logic [5:0]  inc6;
    logic [6:0]  nf;
    logic [15:0] rl;
    logic        do_show;

    // effective frame count saturates at the table depth
    assign n = (11'(cfg.frame_count) > MAXF) ? 7'(MAXF) : cfg.frame_count;

    always_comb begin
        units = '0;
        if (st.cur_frame < n) begin
            units = 17'(delay);
            if (st.cur_frame == 7'd0 && st.wrapped_once) begin
                units = units + 17'(cfg.repeat_delay);
            end
        end
    end

    assign interval = 49'(units) * 49'(cfg.delay_per_unit);

    always_comb begin
        st_next = st;
        res     = '0;
        do_show = 1'b0;
        esum    = {1'b0, st.elapsed} + 49'(item.tick_time);
        e1      = esum[48] ? ELAPSED_MAX : esum[47:0];
        e2      = e1 - interval[47:0];
        inc6    = st.cur_frame[5:0] + 6'd1;
        nf      = {1'b0, inc6};
        rl      = st.repeats_left - 16'd1;
        last    = (n == 7'd0) ? 7'd0 : n - 7'd1;
        res_end = (cfg.end_frame[6] || cfg.end_frame > last) ? last : cfg.end_frame;

        unique case (item.opcode)
            OP_TICK: begin
                if (n != 7'd0) begin
                    st_next.elapsed = e1;
                    if ({1'b0, e1} >= interval) begin
                        // leftover time clamped to one unit
                        st_next.elapsed = (e2 > 48'(cfg.delay_per_unit)) ?
                                          48'(cfg.delay_per_unit) : e2;
                        if (nf > last || nf == 7'd0) begin
                            nf = 7'd0;
                            st_next.wrapped_once = 1'b1;
                        end
                        st_next.cur_frame = nf;
                        priority if (st.play_status == ST_JUMP_PENDING) begin
                            st_next.cur_frame   = {1'b0, cfg.start_frame};
                            st_next.play_status = ST_PLAYING;
                        end else if (st.play_status == ST_STOP_PENDING) begin
                            st_next.cur_frame   = st.resolved_stop;
                            st_next.play_status = ST_STOPPED;
                            res.completed       = 1'b1;
                        end else if (nf == st.resolved_end) begin
                            if (st.repeats_left != 16'd0) begin
                                st_next.repeats_left = rl;
                                st_next.play_status  = (rl == 16'd0) ?
                                                       ST_STOP_PENDING : ST_JUMP_PENDING;
                            end else if (cfg.start_frame != 6'd0) begin
                                st_next.play_status = ST_JUMP_PENDING;
                            end
                        end
                        do_show = 1'b1;
                    end
                end
            end
            OP_LOAD: begin
                st_next = st;
            end
            OP_RESTART: begin
                st_next.resolved_end  = res_end;
                st_next.resolved_stop = cfg.stop_frame[6] ? res_end :
                                        {1'b0, cfg.stop_frame[5:0]};
                st_next.repeats_left  = cfg.repeat_times;
                st_next.cur_frame     = {1'b0, cfg.start_frame};
                st_next.elapsed       = '0;
                st_next.play_status   = ST_PLAYING;
                st_next.wrapped_once  = 1'b0;
                st_next.shown_frame   = NONE_SHOWN;
                do_show               = 1'b1;
            end
            OP_SEEK: begin
                st_next.cur_frame = {1'b0, item.frame_index};
                st_next.elapsed   = '0;
                do_show           = 1'b1;
            end
            default: begin
                st_next = st;
            end
        endcase

        // out-of-range frames are never shown
        if (do_show && st_next.cur_frame != st_next.shown_frame &&
            st_next.cur_frame < n) begin
            st_next.shown_frame = st_next.cur_frame;
            res.new_frame_shown = 1'b1;
        end
        res.current_frame = st_next.cur_frame[5:0];
    end

endmodule
